// File: src/paren_tree_to_heap_array_macros.svh
// Assertion macros for the parenthesised tree to heap array block.
`ifndef PAREN_TREE_TO_HEAP_ARRAY_MACROS_SVH
`define PAREN_TREE_TO_HEAP_ARRAY_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define PTTHA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define PTTHA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PTTHA_ASSERT(lbl, clk, rst, prop, msg)
`define PTTHA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: src/pttha_pkg.sv
// Shared types, constants and helper functions of the heap array builder.
package pttha_pkg;

   localparam int TREE_LEVELS = 7;
   localparam int SLOTS       = 1 << TREE_LEVELS;
   localparam int SLOT_W      = 7;
   localparam int VALUE_W     = 8;
   localparam int LEVELS_W    = 3;
   localparam int LEVELS_MAX  = (1 << LEVELS_W) - 1;
   localparam int LVL_W       = $clog2(TREE_LEVELS + 1);

   localparam logic [VALUE_W-1:0] SYM_OPEN  = 8'h28;
   localparam logic [VALUE_W-1:0] SYM_CLOSE = 8'h29;
   localparam logic [VALUE_W-1:0] SYM_COMMA = 8'h2C;

   typedef logic [TREE_LEVELS-1:0] addr_type;
   typedef logic [LVL_W-1:0]       lvl_type;

   typedef enum logic [1:0] {
      OP_FEED    = 2'd0,
      OP_READ    = 2'd1,
      OP_RESTART = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NO_PARENT  = 3'd1,
      ST_DUPLICATE  = 3'd2,
      ST_TOO_DEEP   = 3'd3,
      ST_UNBALANCED = 3'd4,
      ST_REJECTED   = 3'd5
   } status_type;

   typedef struct packed {
      op_type               op;
      logic [VALUE_W-1:0]   symbol;
      logic [SLOT_W-1:0]    read_slot;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [SLOT_W-1:0]    slot;
      logic [VALUE_W-1:0]   entry_value;
      logic                 entry_valid;
      logic [LEVELS_W-1:0]  levels;
   } rsp_type;

   // Result of one request as decided in the accept cycle.
   typedef struct packed {
      status_type           status;
      logic [SLOT_W-1:0]    slot;
      logic [VALUE_W-1:0]   value;
      logic                 entry_valid;
      logic [LEVELS_W-1:0]  levels;
      logic                 from_ram;
   } meta_type;

   typedef struct packed {
      logic                 wr_en;
      addr_type             wr_addr;
      logic [VALUE_W-1:0]   wr_data;
      logic                 rd_en;
      addr_type             rd_addr;
   } mem_cmd_type;

   // Level of a heap slot: position of its leading one, root at level one.
   function automatic lvl_type level_of(addr_type s);
      lvl_type lvl;
      lvl = '0;
      for (int i = 0; i < TREE_LEVELS; i++) begin
         if (s[i]) begin
            lvl = LVL_W'(i + 1);
         end
      end
      return lvl;
   endfunction

   function automatic logic [LEVELS_W-1:0] sat_levels(lvl_type l);
      logic [LEVELS_W-1:0] r;
      if (int'(l) > LEVELS_MAX) begin
         r = LEVELS_W'(LEVELS_MAX);
      end else begin
         r = LEVELS_W'(l);
      end
      return r;
   endfunction

endpackage

// File: src/paren_tree_to_heap_array.sv
// Top level: request decode, node store RAM and the two-stage response pipeline.
//
// Builds a heap-order array from a parenthesised binary-tree text fed one
// character per request, and serves reads of stored slots. One request is
// taken every cycle while the response stages keep moving. The accepting
// edge updates the cursor, presence bits and flags, loads the first stage
// and, for a read, the node store RAM's registered read data; the response
// register loads from the first stage once it is empty or being taken, and
// presents the response. At most two requests are in flight: with both
// stages held and rsp_ready low, req_ready drops, and it rises in the same
// cycle that rsp_ready frees a stage. The rate is set by the single read
// and single write port of the node store: a feed writes it and a read
// reads it, each once. Presence bits sit in flip-flops cleared at reset and
// on restart at once, so no clearing pass is needed and the block is ready
// from the first cycle after reset.
`include "paren_tree_to_heap_array_macros.svh"

module paren_tree_to_heap_array (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pttha_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pttha_pkg::rsp_type  rsp_data
);

   pttha_pkg::meta_type     meta;
   pttha_pkg::mem_cmd_type  mem_cmd;
   logic [pttha_pkg::VALUE_W-1:0] ram_q;

   logic                    fire;
   logic                    s2_load;
   logic                    s1_valid_ff;
   pttha_pkg::meta_type     s1_meta_ff;
   logic                    s2_valid_ff;
   pttha_pkg::rsp_type      s2_data_ff, s2_data_in;

   assign fire      = req_valid && req_ready;
   assign s2_load   = s1_valid_ff && (!s2_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s2_load;

   pttha_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .req     (req_data),
      .meta    (meta),
      .mem_cmd (mem_cmd)
   );

   pttha_ram #(
      .DATA_W (pttha_pkg::VALUE_W),
      .ADDR_W (pttha_pkg::TREE_LEVELS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_cmd.wr_en),
      .wr_addr (mem_cmd.wr_addr),
      .wr_data (mem_cmd.wr_data),
      .rd_en   (mem_cmd.rd_en),
      .rd_addr (mem_cmd.rd_addr),
      .rd_data (ram_q)
   );

   // Take the stored byte for reads; the RAM output holds until the next read.
   always_comb begin
      s2_data_in.status      = s1_meta_ff.status;
      s2_data_in.slot        = s1_meta_ff.slot;
      s2_data_in.entry_value = s1_meta_ff.from_ram ? ram_q : s1_meta_ff.value;
      s2_data_in.entry_valid = s1_meta_ff.entry_valid;
      s2_data_in.levels      = s1_meta_ff.levels;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s2_load) begin
            s1_valid_ff <= 1'b0;
         end
         if (s2_load) begin
            s2_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            s2_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         s1_meta_ff <= meta;
      end
      if (s2_load) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign rsp_valid = s2_valid_ff;
   assign rsp_data  = s2_data_ff;

   `PTTHA_ASSERT(a_fire_fills_s1, clock, reset, fire |=> s1_valid_ff, "accepted request lost before response stage")
   `PTTHA_ASSERT(a_backpressure, clock, reset, s1_valid_ff && s2_valid_ff && !rsp_ready |-> !req_ready, "request taken with both stages stalled")
   `PTTHA_ASSERT(a_valid_means_ok, clock, reset, rsp_valid && rsp_data.entry_valid |-> rsp_data.status == pttha_pkg::ST_OK, "entry marked valid on an error response")
   `PTTHA_ASSERT(a_reject_clean, clock, reset, rsp_valid && rsp_data.status == pttha_pkg::ST_REJECTED |-> rsp_data.slot == '0 && rsp_data.entry_value == '0, "rejected response carries data")

endmodule

// File: src/pttha_ram.sv
// Generic single write port, single read port RAM with registered read data.
module pttha_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] store_ff [(1 << ADDR_W)];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/pttha_ctrl.sv
// Cursor, presence bits and error flag; decides each request and drives the node store.
`include "paren_tree_to_heap_array_macros.svh"

module pttha_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  pttha_pkg::req_type   req,
   output pttha_pkg::meta_type  meta,
   output pttha_pkg::mem_cmd_type mem_cmd
);

   pttha_pkg::addr_type              cursor_ff, cursor_in;
   logic [pttha_pkg::SLOTS-1:0]      present_ff, present_in;
   pttha_pkg::lvl_type               level_ff, level_in;
   logic                             failed_ff, failed_in;

   logic [pttha_pkg::TREE_LEVELS:0]  step;
   pttha_pkg::addr_type              parent;
   pttha_pkg::addr_type              rd_idx;
   pttha_pkg::lvl_type               cur_lvl;
   logic                             rd_in_range;
   logic                             wr_en;
   logic                             rd_en;

   assign parent      = cursor_ff >> 1;
   assign rd_idx      = pttha_pkg::TREE_LEVELS'(req.read_slot);
   assign rd_in_range = (req.read_slot >> pttha_pkg::TREE_LEVELS) == '0;
   assign cur_lvl     = pttha_pkg::level_of(cursor_ff);

   always_comb begin
      cursor_in  = cursor_ff;
      present_in = present_ff;
      level_in   = level_ff;
      failed_in  = failed_ff;
      step       = '0;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      meta       = '0;
      meta.status = pttha_pkg::ST_OK;

      unique case (req.op)
         pttha_pkg::OP_FEED: begin
            if (failed_ff) begin
               meta.status = pttha_pkg::ST_REJECTED;
            end else begin
               unique case (req.symbol) inside
                  pttha_pkg::SYM_OPEN, pttha_pkg::SYM_COMMA: begin
                     if (req.symbol == pttha_pkg::SYM_OPEN) begin
                        step = {cursor_ff, 1'b0};
                     end else begin
                        step = {1'b0, cursor_ff} + 1'b1;
                     end
                     // Top bit set means the move leaves the store.
                     if (step[pttha_pkg::TREE_LEVELS]) begin
                        meta.status = pttha_pkg::ST_TOO_DEEP;
                        failed_in   = 1'b1;
                     end else begin
                        cursor_in = step[pttha_pkg::TREE_LEVELS-1:0];
                     end
                  end
                  pttha_pkg::SYM_CLOSE: begin
                     if (parent == '0) begin
                        meta.status = pttha_pkg::ST_UNBALANCED;
                        failed_in   = 1'b1;
                     end else begin
                        cursor_in = parent;
                     end
                  end
                  default: begin
                     meta.slot  = pttha_pkg::SLOT_W'(cursor_ff);
                     meta.value = req.symbol;
                     if (parent != '0 && !present_ff[parent]) begin
                        meta.status = pttha_pkg::ST_NO_PARENT;
                        failed_in   = 1'b1;
                     end else if (present_ff[cursor_ff]) begin
                        meta.status = pttha_pkg::ST_DUPLICATE;
                        failed_in   = 1'b1;
                     end else begin
                        wr_en                 = 1'b1;
                        present_in[cursor_ff] = 1'b1;
                        meta.entry_valid      = 1'b1;
                        if (cur_lvl > level_ff) begin
                           level_in = cur_lvl;
                        end
                     end
                  end
               endcase
            end
         end
         pttha_pkg::OP_READ: begin
            meta.slot = req.read_slot;
            if (rd_in_range && present_ff[rd_idx]) begin
               rd_en            = 1'b1;
               meta.entry_valid = 1'b1;
               meta.from_ram    = 1'b1;
            end
         end
         pttha_pkg::OP_RESTART: begin
            present_in = '0;
            cursor_in  = pttha_pkg::TREE_LEVELS'(1);
            level_in   = '0;
            failed_in  = 1'b0;
         end
         default: begin
         end
      endcase

      meta.levels = pttha_pkg::sat_levels(level_in);
   end

   always_comb begin
      mem_cmd.wr_en   = fire && wr_en;
      mem_cmd.wr_addr = cursor_ff;
      mem_cmd.wr_data = req.symbol;
      mem_cmd.rd_en   = fire && rd_en;
      mem_cmd.rd_addr = rd_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff  <= pttha_pkg::TREE_LEVELS'(1);
         present_ff <= '0;
         level_ff   <= '0;
         failed_ff  <= 1'b0;
      end else if (fire) begin
         cursor_ff  <= cursor_in;
         present_ff <= present_in;
         level_ff   <= level_in;
         failed_ff  <= failed_in;
      end
   end

   `PTTHA_ASSERT(a_cursor_nonzero, clock, reset, cursor_ff != '0, "cursor reached slot zero")
   `PTTHA_ASSERT(a_failed_sticky, clock, reset, failed_ff && !(fire && req.op == pttha_pkg::OP_RESTART) |=> failed_ff, "failed flag dropped without restart")
   `PTTHA_ASSERT(a_write_marks, clock, reset, mem_cmd.wr_en |=> present_ff[$past(cursor_ff)], "written slot not marked present")

endmodule
